/* hw/rtl/set_assoc_lru_cache_core_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the cache core RTL
// Each macro is one labeled concurrent assertion sampled on clk.
// ---------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_CORE_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_CORE_DEFINES_SVH

// Checked only while out of reset.
`define SLC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SLC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/slc_pkg.sv */
// ---------------------------------------------------------------------------
// slc_pkg
// Geometry constants, set metadata row type and lookup result type.
// ---------------------------------------------------------------------------
package slc_pkg;

	localparam int MAX_WAYS         = 8;
	localparam int MAX_SETS         = 64;
	localparam int MAX_BLOCK_BYTES  = 64;
	localparam int MEM_BYTES        = 65536;
	localparam int MAX_ACCESS_BYTES = 8;

	localparam int ADDR_W      = 16;
	localparam int WAY_W       = 3;
	localparam int SET_W       = 6;
	localparam int TAG_W       = 14;
	localparam int AGE_W       = 3;
	localparam int WORD_BYTES  = 8;
	localparam int WORD_W      = 64;
	localparam int WIDX_W      = 3;
	localparam int LINE_ADDR_W = SET_W + WAY_W + WIDX_W;
	localparam int MEM_ADDR_W  = 13;

	typedef enum logic [1:0] {
		REG_WB_MODE    = 2'd0,
		REG_WAYS       = 2'd1,
		REG_SETS_LOG2  = 2'd2,
		REG_BLOCK_LOG2 = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_STORE = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic [MAX_WAYS-1:0]                valid;
		logic [MAX_WAYS-1:0]                dirty;
		logic [MAX_WAYS-1:0][TAG_W-1:0]     tag;
		logic [MAX_WAYS-1:0][AGE_W-1:0]     age;
	} meta_row_t;

	localparam int META_W = $bits(meta_row_t);

	typedef struct packed {
		logic             hit;
		logic [WAY_W-1:0] way;
		logic             evict;
		logic [TAG_W-1:0] old_tag;
		meta_row_t        new_row;
	} lookup_t;

	// Row after reset or a geometry change: nothing valid, ages descending.
	function automatic meta_row_t reset_row(input logic [3:0] ways);
		meta_row_t r;
		r = '0;
		for (int k = 0; k < MAX_WAYS; k++) begin
			if (4'(k) < ways)
				r.age[k] = AGE_W'(ways - 4'd1 - 4'(k));
		end
		return r;
	endfunction

endpackage

/* hw/rtl/slc_ram.sv */
// ---------------------------------------------------------------------------
// slc_ram
// Single-port synchronous RAM with lane write enables, registered read.
// ---------------------------------------------------------------------------
module slc_ram #(
	parameter int ADDR_W = 8,
	parameter int LANES  = 1,
	parameter int LANE_W = 8
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [LANES-1:0]        be,
	input  logic [ADDR_W-1:0]       addr,
	input  logic [LANES*LANE_W-1:0] wdata,
	output logic [LANES*LANE_W-1:0] rdata
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [LANES*LANE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			for (int i = 0; i < LANES; i++) begin
				if (be[i])
					mem_q[addr][i*LANE_W +: LANE_W] <= wdata[i*LANE_W +: LANE_W];
			end
		end
		rdata <= mem_q[addr];
	end

endmodule

/* hw/rtl/slc_lookup.sv */
// ---------------------------------------------------------------------------
// slc_lookup
// Tag match, LRU victim choice and updated set row for one access.
// ---------------------------------------------------------------------------
module slc_lookup (
	input  slc_pkg::meta_row_t           row,
	input  logic [slc_pkg::TAG_W-1:0]    tag,
	input  logic [3:0]                   ways,
	input  logic                         set_dirty,
	output slc_pkg::lookup_t             lk
);

	logic                        hit;
	logic [slc_pkg::WAY_W-1:0]   hit_way;
	logic [slc_pkg::WAY_W-1:0]   victim;
	logic [slc_pkg::WAY_W-1:0]   sel;
	logic [slc_pkg::AGE_W-1:0]   prev;
	logic [slc_pkg::AGE_W-1:0]   oldest;
	slc_pkg::meta_row_t          nr;

	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		victim  = '0;
		oldest  = slc_pkg::AGE_W'(ways - 4'd1);
		for (int k = slc_pkg::MAX_WAYS - 1; k >= 0; k--) begin
			if (4'(k) < ways && row.valid[k] && row.tag[k] == tag) begin
				hit     = 1'b1;
				hit_way = slc_pkg::WAY_W'(k);
			end
			if (4'(k) < ways && row.age[k] == oldest)
				victim = slc_pkg::WAY_W'(k);
		end
		sel  = hit ? hit_way : victim;
		prev = row.age[sel];

		// age the ways younger than the touched one
		nr = row;
		for (int k = 0; k < slc_pkg::MAX_WAYS; k++) begin
			if (4'(k) < ways && slc_pkg::WAY_W'(k) != sel && row.age[k] < prev)
				nr.age[k] = row.age[k] + slc_pkg::AGE_W'(1);
		end
		nr.age[sel] = '0;
		if (hit) begin
			nr.dirty[sel] = row.dirty[sel] | set_dirty;
		end else begin
			nr.valid[sel] = 1'b1;
			nr.dirty[sel] = set_dirty;
			nr.tag[sel]   = tag;
		end

		lk.hit     = hit;
		lk.way     = sel;
		lk.evict   = !hit && row.valid[victim] && row.dirty[victim];
		lk.old_tag = row.tag[victim];
		lk.new_row = nr;
	end

endmodule

/* hw/rtl/set_assoc_lru_cache_core.sv */
// ---------------------------------------------------------------------------
// set_assoc_lru_cache_core
// Set-associative LRU cache over a cleared byte memory, load/store requests.
// ---------------------------------------------------------------------------
//  channel | dir | tdata                                   | tuser
//  s_*     | in  | address, access_size, store_data, pad   | req_type
//  m_*     | out | load_data                               | hit, access_error
//  cfg_*   | in  | register index cfg_index, value cfg_wdata
//
// Load hit: LOOKUP, LD0, LD1, LD2, RESP; store hit: LOOKUP, ST0, ST1, RESP;
// block-crossing error: straight to RESP. An allocating miss first writes a
// dirty victim back per word (WB_RD, WB_WR), then fills per 8-byte word
// (FILL_RD, FILL_WR). After reset the backing memory and the 64 set rows are
// cleared; a geometry write clears the 64 set rows. s_tready is low meanwhile.
// One request is in flight; the next is taken while a result waits on m_*.
// ---------------------------------------------------------------------------
`include "set_assoc_lru_cache_core_defines.svh"

module set_assoc_lru_cache_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,   // [15:0] address, [19:16] access_size, [83:20] store_data
	input  logic        s_tuser,   // [0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [63:0] load_data
	output logic [1:0]  m_tuser,   // [0] hit, [1] access_error
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_wdata
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOOKUP, ST_WB_RD, ST_WB_WR, ST_FILL_RD, ST_FILL_WR,
		ST_LD0, ST_LD1, ST_LD2, ST_ST0, ST_ST1, ST_RESP
	} state_t;

	state_t state_q;

	// configuration
	logic       wb_mode_q;
	logic [3:0] ways_q;
	logic [2:0] sets_q;
	logic [2:0] bsize_q;

	logic [3:0] ways_eff;
	logic [2:0] sl2_eff;
	logic [2:0] bl2;
	logic [slc_pkg::SET_W-1:0]  set_mask;
	logic [6:0] blk_bytes;
	logic [slc_pkg::WIDX_W-1:0] nw_last;

	always_comb begin
		ways_eff = (ways_q == 4'd0) ? 4'd1 :
			(ways_q > 4'(slc_pkg::MAX_WAYS)) ? 4'(slc_pkg::MAX_WAYS) : ways_q;
		sl2_eff  = (sets_q > 3'(slc_pkg::SET_W)) ? 3'(slc_pkg::SET_W) : sets_q;
		bl2      = (bsize_q < 3'd2) ? 3'd2 : (bsize_q > 3'd6) ? 3'd6 : bsize_q;
		set_mask = slc_pkg::SET_W'((7'd1 << sl2_eff) - 7'd1);
		blk_bytes = 7'd1 << bl2;
		nw_last  = (bl2 > 3'd3) ? slc_pkg::WIDX_W'((4'd1 << (bl2 - 3'd3)) - 4'd1) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_mode_q <= 1'b0;
			ways_q    <= 4'd8;
			sets_q    <= 3'd6;
			bsize_q   <= 3'd4;
		end else if (cfg_we) begin
			unique case (slc_pkg::cfg_reg_t'(cfg_index))
				slc_pkg::REG_WB_MODE:    wb_mode_q <= cfg_wdata[0];
				slc_pkg::REG_WAYS:       ways_q    <= cfg_wdata;
				slc_pkg::REG_SETS_LOG2:  sets_q    <= cfg_wdata[2:0];
				slc_pkg::REG_BLOCK_LOG2: bsize_q   <= cfg_wdata[2:0];
			endcase
		end
	end

	// clearing passes
	logic                           mem_clr_q;
	logic [slc_pkg::MEM_ADDR_W-1:0] mem_cnt_q;
	logic                           meta_clr_q;
	logic [slc_pkg::SET_W-1:0]      meta_cnt_q;
	logic                           geo_wr;

	assign geo_wr = cfg_we && (slc_pkg::cfg_reg_t'(cfg_index) != slc_pkg::REG_WB_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_clr_q  <= 1'b1;
			mem_cnt_q  <= '0;
			meta_clr_q <= 1'b1;
			meta_cnt_q <= '0;
		end else begin
			if (mem_clr_q) begin
				mem_cnt_q <= mem_cnt_q + 1'b1;
				if (&mem_cnt_q)
					mem_clr_q <= 1'b0;
			end
			if (geo_wr) begin
				meta_clr_q <= 1'b1;
				meta_cnt_q <= '0;
			end else if (meta_clr_q) begin
				meta_cnt_q <= meta_cnt_q + 1'b1;
				if (&meta_cnt_q)
					meta_clr_q <= 1'b0;
			end
		end
	end

	// request decode
	logic [15:0] in_addr;
	logic [3:0]  in_size;
	logic [15:0] in_blk;
	logic [5:0]  in_off;
	logic        in_err;
	logic [slc_pkg::SET_W-1:0] in_set;

	always_comb begin
		in_addr = s_tdata[15:0];
		in_size = (s_tdata[19:16] == 4'd0) ? 4'd1 :
			(s_tdata[19:16] > 4'(slc_pkg::MAX_ACCESS_BYTES)) ?
			4'(slc_pkg::MAX_ACCESS_BYTES) : s_tdata[19:16];
		in_blk  = in_addr >> bl2;
		in_off  = in_addr[5:0] & 6'(blk_bytes - 7'd1);
		in_set  = in_blk[slc_pkg::SET_W-1:0] & set_mask;
		in_err  = (7'(in_off) + 7'(in_size)) > blk_bytes;
	end

	assign s_tready = (state_q == ST_IDLE) && !mem_clr_q && !meta_clr_q;

	// request and working registers
	logic                        store_q;
	logic [15:0]                 addr_q;
	logic [7:0]                  smask_q;
	logic [63:0]                 sdata_q;
	logic [slc_pkg::SET_W-1:0]   set_q;
	logic [slc_pkg::TAG_W-1:0]   tag_q;
	logic [slc_pkg::WAY_W-1:0]   way_q;
	logic [slc_pkg::TAG_W-1:0]   old_tag_q;
	logic                        cache_wr_q;
	logic                        mem_wr_q;
	logic [slc_pkg::WIDX_W-1:0]  j_q;
	logic [63:0]                 lo_q;
	logic                        res_hit_q;
	logic                        res_err_q;
	logic [63:0]                 res_data_q;
	logic                        m_tvalid_q;
	logic [63:0]                 m_tdata_q;
	logic [1:0]                  m_tuser_q;

	// memories
	slc_pkg::meta_row_t              meta_rd;
	slc_pkg::meta_row_t              meta_wd;
	logic                            meta_we;
	logic [slc_pkg::SET_W-1:0]       meta_addr;
	logic [slc_pkg::META_W-1:0]      meta_rdata;

	logic                            line_we;
	logic [7:0]                      line_be;
	logic [slc_pkg::LINE_ADDR_W-1:0] line_addr;
	logic [63:0]                     line_wdata;
	logic [63:0]                     line_rdata;

	logic                            mem_we;
	logic [7:0]                      mem_be;
	logic [slc_pkg::MEM_ADDR_W-1:0]  mem_addr;
	logic [63:0]                     mem_wdata;
	logic [63:0]                     mem_rdata;

	slc_pkg::lookup_t                lk;
	logic                            alloc;

	assign meta_rd = slc_pkg::meta_row_t'(meta_rdata);

	slc_lookup u_lookup (
		.row       (meta_rd),
		.tag       (tag_q),
		.ways      (ways_eff),
		.set_dirty (store_q && wb_mode_q),
		.lk        (lk)
	);

	assign alloc = !lk.hit && (!store_q || wb_mode_q);

	// address and lane helpers
	logic [slc_pkg::WIDX_W-1:0]      w0;
	logic [15:0]                     old_base;
	logic [slc_pkg::MEM_ADDR_W-1:0]  new_word;
	logic [slc_pkg::MEM_ADDR_W-1:0]  old_word;
	logic [7:0]                      new_be;
	logic [7:0]                      old_be;
	logic [127:0]                    st_win;
	logic [15:0]                     st_be;
	logic [127:0]                    ld_win;
	logic [63:0]                     ld_mask;

	always_comb begin
		w0       = slc_pkg::WIDX_W'(6'(addr_q[5:0] & 6'(blk_bytes - 7'd1)) >> 3);
		old_base = 16'({2'b0, old_tag_q} << bl2);
		new_word = (addr_q[15:3] & ~slc_pkg::MEM_ADDR_W'(nw_last)) |
			slc_pkg::MEM_ADDR_W'(j_q);
		old_word = old_base[15:3] | slc_pkg::MEM_ADDR_W'(j_q);
		new_be   = (bl2 == 3'd2) ? (addr_q[2] ? 8'hF0 : 8'h0F) : 8'hFF;
		old_be   = (bl2 == 3'd2) ? (old_base[2] ? 8'hF0 : 8'h0F) : 8'hFF;
		st_win   = {64'd0, sdata_q} << {addr_q[2:0], 3'b000};
		st_be    = {8'd0, smask_q} << addr_q[2:0];
		ld_win   = {line_rdata, lo_q} >> {addr_q[2:0], 3'b000};
		for (int i = 0; i < 8; i++)
			ld_mask[i*8 +: 8] = {8{smask_q[i]}};
	end

	// RAM port steering
	always_comb begin
		meta_we   = meta_clr_q || (state_q == ST_LOOKUP && (lk.hit || alloc));
		meta_addr = meta_clr_q ? meta_cnt_q : (state_q == ST_IDLE) ? in_set : set_q;
		meta_wd   = meta_clr_q ? slc_pkg::reset_row(ways_eff) : lk.new_row;

		line_we    = 1'b0;
		line_be    = 8'h00;
		line_addr  = {set_q, way_q, j_q};
		line_wdata = mem_rdata;
		mem_we     = mem_clr_q;
		mem_be     = 8'hFF;
		mem_addr   = mem_cnt_q;
		mem_wdata  = '0;

		unique case (state_q)
			ST_WB_WR: begin
				mem_we    = 1'b1;
				mem_be    = old_be;
				mem_addr  = old_word;
				mem_wdata = line_rdata;
			end
			ST_FILL_RD: begin
				mem_addr = new_word;
			end
			ST_FILL_WR: begin
				line_we = 1'b1;
				line_be = new_be;
			end
			ST_LD0: begin
				line_addr = {set_q, way_q, w0};
			end
			ST_LD1: begin
				line_addr = {set_q, way_q, w0 + 1'b1};
			end
			ST_ST0: begin
				line_we    = cache_wr_q;
				line_be    = st_be[7:0];
				line_addr  = {set_q, way_q, w0};
				line_wdata = st_win[63:0];
				mem_we     = mem_wr_q;
				mem_be     = st_be[7:0];
				mem_addr   = addr_q[15:3];
				mem_wdata  = st_win[63:0];
			end
			ST_ST1: begin
				line_we    = cache_wr_q;
				line_be    = st_be[15:8];
				line_addr  = {set_q, way_q, w0 + 1'b1};
				line_wdata = st_win[127:64];
				mem_we     = mem_wr_q;
				mem_be     = st_be[15:8];
				mem_addr   = addr_q[15:3] + 1'b1;
				mem_wdata  = st_win[127:64];
			end
			default: begin
			end
		endcase
	end

	slc_ram #(.ADDR_W(slc_pkg::SET_W), .LANES(1), .LANE_W(slc_pkg::META_W)) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.be    (1'b1),
		.addr  (meta_addr),
		.wdata (meta_wd),
		.rdata (meta_rdata)
	);

	slc_ram #(.ADDR_W(slc_pkg::LINE_ADDR_W), .LANES(8), .LANE_W(8)) u_line_ram (
		.clk   (clk),
		.we    (line_we),
		.be    (line_be),
		.addr  (line_addr),
		.wdata (line_wdata),
		.rdata (line_rdata)
	);

	slc_ram #(.ADDR_W(slc_pkg::MEM_ADDR_W), .LANES(8), .LANE_W(8)) u_main_ram (
		.clk   (clk),
		.we    (mem_we),
		.be    (mem_be),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
		end else begin
			// the response state reloads the output register itself
			if (m_tvalid_q && m_tready && state_q != ST_RESP)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						store_q    <= (slc_pkg::req_kind_t'(s_tuser) == slc_pkg::REQ_STORE);
						addr_q     <= in_addr;
						smask_q    <= 8'((9'd1 << in_size) - 9'd1);
						sdata_q    <= s_tdata[83:20];
						set_q      <= in_set;
						tag_q      <= in_blk[slc_pkg::TAG_W-1:0];
						res_hit_q  <= 1'b0;
						res_err_q  <= in_err;
						res_data_q <= '0;
						state_q    <= in_err ? ST_RESP : ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					way_q      <= lk.way;
					old_tag_q  <= lk.old_tag;
					res_hit_q  <= lk.hit;
					cache_wr_q <= store_q && (wb_mode_q || lk.hit);
					mem_wr_q   <= store_q && !wb_mode_q;
					j_q        <= '0;
					if (alloc)
						state_q <= lk.evict ? ST_WB_RD : ST_FILL_RD;
					else
						state_q <= store_q ? ST_ST0 : ST_LD0;
				end
				ST_WB_RD: state_q <= ST_WB_WR;
				ST_WB_WR: begin
					if (j_q == nw_last) begin
						j_q     <= '0;
						state_q <= ST_FILL_RD;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_WB_RD;
					end
				end
				ST_FILL_RD: state_q <= ST_FILL_WR;
				ST_FILL_WR: begin
					if (j_q == nw_last)
						state_q <= store_q ? ST_ST0 : ST_LD0;
					else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_FILL_RD;
					end
				end
				ST_LD0: state_q <= ST_LD1;
				ST_LD1: begin
					lo_q    <= line_rdata;
					state_q <= ST_LD2;
				end
				ST_LD2: begin
					res_data_q <= ld_win[63:0] & ld_mask;
					state_q    <= ST_RESP;
				end
				ST_ST0: state_q <= ST_ST1;
				ST_ST1: state_q <= ST_RESP;
				ST_RESP: begin
					// hold the result until the output register frees up
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= res_data_q;
						m_tuser_q  <= {res_err_q, res_hit_q};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`SLC_ASSERT_ALWAYS(a_no_req_while_clearing, (mem_clr_q || meta_clr_q) |-> !s_tready, "request taken during clearing pass")
	`SLC_ASSERT(a_clear_only_idle, meta_clr_q |-> (state_q == ST_IDLE), "set rows cleared while a request is in flight")
	`SLC_ASSERT(a_meta_write_src, meta_we |-> (meta_clr_q || state_q == ST_LOOKUP), "set row written outside lookup or clearing")
	`SLC_ASSERT(a_err_no_hit, m_tvalid |-> !(m_tuser[0] && m_tuser[1]), "result flags both hit and error")
	`SLC_ASSERT(a_err_zero_data, (m_tvalid && m_tuser[1]) |-> (m_tdata == 64'd0), "error result carries data")

endmodule
